>>> rtl/car_pkg.sv
`timescale 1ns / 1ps
// shared constants, register indexes and filter tables of the reverberator
package car_pkg;

  // default sizes handed to the top level
  localparam int CHANNELS_DEF     = 2;
  localparam int FILTER_SLOTS_DEF = 12;
  localparam int DELAY_DEPTH_DEF  = 8192;
  localparam int SAMPLE_BITS_DEF  = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOM_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALLPASS_GAIN = 2'd3;

  localparam logic [15:0] ROOM_SIZE_RST    = 16'd55050;
  localparam logic [15:0] DAMPING_RST      = 16'd13107;
  localparam logic [15:0] ALLPASS_GAIN_RST = 16'd45875;

  // filter kinds
  localparam logic [1:0] K_LOWPASS = 2'd0;
  localparam logic [1:0] K_FFCOMB  = 2'd1;
  localparam logic [1:0] K_APJC    = 2'd2;
  localparam logic [1:0] K_DIFFUSE = 2'd3;

  localparam logic MODE_FREEVERB = 1'b0;
  localparam logic MODE_JCREV    = 1'b1;

  // filter counts per structure
  localparam logic [3:0] FV_FILTERS = 4'd12;
  localparam logic [3:0] FV_COMBS   = 4'd8;
  localparam logic [3:0] JC_FILTERS = 4'd7;
  localparam logic [3:0] JC_COMBS   = 4'd4;

  // delay of filter f in the selected structure
  function automatic logic [12:0] filt_delay(input logic mode, input logic [3:0] f);
    logic [12:0] d;
    d = 13'd0;
    if (mode == MODE_FREEVERB) begin
      case (f)
        4'd0:    d = 13'd1557;
        4'd1:    d = 13'd1617;
        4'd2:    d = 13'd1491;
        4'd3:    d = 13'd1422;
        4'd4:    d = 13'd1277;
        4'd5:    d = 13'd1356;
        4'd6:    d = 13'd1188;
        4'd7:    d = 13'd1116;
        4'd8:    d = 13'd225;
        4'd9:    d = 13'd556;
        4'd10:   d = 13'd441;
        4'd11:   d = 13'd341;
        default: d = 13'd0;
      endcase
    end else begin
      case (f)
        4'd0:    d = 13'd4799;
        4'd1:    d = 13'd4999;
        4'd2:    d = 13'd5399;
        4'd3:    d = 13'd5899;
        4'd4:    d = 13'd1051;
        4'd5:    d = 13'd337;
        4'd6:    d = 13'd113;
        default: d = 13'd0;
      endcase
    end
    return d;
  endfunction

  // direct gain of the feed-forward combs, unsigned Q0.16
  function automatic logic [15:0] jc_coef(input logic [1:0] i);
    logic [15:0] c;
    case (i)
      2'd0:    c = 16'd48628;
      2'd1:    c = 16'd48038;
      2'd2:    c = 16'd46858;
      default: c = 16'd45679;
    endcase
    return c;
  endfunction

  // filter kind of filter f
  function automatic logic [1:0] filt_kind(input logic mode, input logic [3:0] f);
    logic [1:0] k;
    if (mode == MODE_FREEVERB) k = (f < FV_COMBS) ? K_LOWPASS : K_DIFFUSE;
    else                       k = (f < JC_COMBS) ? K_FFCOMB : K_APJC;
    return k;
  endfunction

endpackage

>>> rtl/car_in_if.sv
`timescale 1ns / 1ps
// sample request channel
interface car_in_if #(parameter int SAMPLE_BITS = car_pkg::SAMPLE_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic                          channel;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  modport source (output valid, channel, sample_in, input ready);
  modport sink   (input valid, channel, sample_in, output ready);
endinterface

>>> rtl/car_out_if.sv
`timescale 1ns / 1ps
// result sample channel
interface car_out_if #(parameter int SAMPLE_BITS = car_pkg::SAMPLE_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic                          out_channel;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  modport source (output valid, out_channel, sample_out, input ready);
  modport sink   (input valid, out_channel, sample_out, output ready);
endinterface

>>> rtl/car_cfg_if.sv
`timescale 1ns / 1ps
// configuration write channel
interface car_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [car_pkg::CFG_IDX_W-1:0]      index;
  logic [car_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/comb_allpass_reverb.sv
`timescale 1ns / 1ps
// reverberator top level: filter sequencer, history memories and arithmetic
//
// One request (channel, sample) gives one reverberated sample for that channel. Mode 0 runs
// eight damped comb filters and four diffusion allpasses, mode 1 runs four feed-forward combs
// and three allpasses with gain allpass_gain. The filters run one after another through a
// single shared datapath; each filter runs through ring lookup, two reads of the history
// memories and a wait step to take the second, two multiply steps, sum, round and saturate,
// and write-back. A new request is taken only once the last result is loaded; the result
// register lets the next request in while a result still waits. After reset the history
// memories are swept to zero, one entry a cycle; requests wait until the sweep is done,
// configuration writes are taken at any time. A channel at or above CHANNELS returns zero.
module comb_allpass_reverb #(
  parameter int CHANNELS     = car_pkg::CHANNELS_DEF,
  parameter int FILTER_SLOTS = car_pkg::FILTER_SLOTS_DEF,
  parameter int DELAY_DEPTH  = car_pkg::DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS  = car_pkg::SAMPLE_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  car_in_if.sink   sample_req,
  car_out_if.source result,
  car_cfg_if.sink  cfg
);
  import car_pkg::*;

  localparam int SB        = SAMPLE_BITS;
  localparam int ROWS      = CHANNELS * FILTER_SLOTS;
  localparam int MEM_DEPTH = ROWS * DELAY_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int RW        = $clog2(ROWS);
  localparam int PW        = $clog2(DELAY_DEPTH);
  localparam int LW        = $clog2(DELAY_DEPTH + 1);
  localparam int ACCW      = SB + 42;
  localparam int MW        = SB + 17;
  localparam int M4W       = SB + 34;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_ADDR  = 4'd2;
  localparam logic [3:0] ST_RD1   = 4'd3;
  localparam logic [3:0] ST_RD2   = 4'd4;
  localparam logic [3:0] ST_WAIT  = 4'd5;
  localparam logic [3:0] ST_MUL1  = 4'd6;
  localparam logic [3:0] ST_MUL2  = 4'd7;
  localparam logic [3:0] ST_ACC   = 4'd8;
  localparam logic [3:0] ST_RND   = 4'd9;
  localparam logic [3:0] ST_WR    = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  // configuration registers
  logic        mode;
  logic [15:0] room_size;
  logic [15:0] damping;
  logic [15:0] allpass_gain;

  // control
  logic [3:0]    state;
  logic [AW-1:0] clr_cnt;
  logic [3:0]    f;
  logic          ch;
  logic [PW-1:0] ring_pos [ROWS];

  // datapath
  logic signed [SB-1:0]   s_in, v, xin, x1, y1, xd, yd, y, res;
  logic signed [SB+3:0]   sum;
  logic [1:0]             kind;
  logic [RW-1:0]          row;
  logic [AW-1:0]          base;
  logic [PW-1:0]          p, pm1, pd;
  logic signed [MW-1:0]   m1, m2;
  logic [32:0]            m3;
  logic signed [M4W-1:0]  m4;
  logic signed [ACCW-1:0] acc;

  // history memories
  logic signed [SB-1:0] xmem [MEM_DEPTH];
  logic signed [SB-1:0] ymem [MEM_DEPTH];
  logic signed [SB-1:0] xq, yq;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic signed [SB-1:0] wr_x, wr_y;

  // output register
  logic                 out_valid;
  logic                 out_ch;
  logic signed [SB-1:0] out_sample;

  function automatic logic signed [SB-1:0] sat_acc(input logic signed [ACCW-1:0] a);
    logic signed [ACCW-1:0] hi, lo;
    hi = ACCW'((64'sd1 <<< (SB - 1)) - 64'sd1);
    lo = -hi - ACCW'(1);
    if (a > hi)      return SB'(hi);
    else if (a < lo) return SB'(lo);
    else             return SB'(a);
  endfunction

  // handshakes
  assign sample_req.ready  = (state == ST_IDLE);
  assign cfg.ready         = 1'b1;
  assign result.valid      = out_valid;
  assign result.out_channel = out_ch;
  assign result.sample_out = out_sample;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_FREEVERB;
      room_size    <= ROOM_SIZE_RST;
      damping      <= DAMPING_RST;
      allpass_gain <= ALLPASS_GAIN_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MODE:         mode         <= cfg.data[0];
        REG_ROOM_SIZE:    room_size    <= cfg.data;
        REG_DAMPING:      damping      <= cfg.data;
        REG_ALLPASS_GAIN: allpass_gain <= cfg.data;
        default: ;
      endcase
    end
  end

  // ring lookup for the filter about to start
  logic [3:0]    n_filt, n_comb;
  logic [RW-1:0] row_c;
  logic [12:0]   dly_c;
  logic [LW-1:0] len_c, p_ext, p_c, pm1_c, pd_c;
  always_comb begin
    n_filt = (mode == MODE_JCREV) ? JC_FILTERS : FV_FILTERS;
    n_comb = (mode == MODE_JCREV) ? JC_COMBS : FV_COMBS;
    row_c  = RW'(int'(ch) * FILTER_SLOTS + int'(f));
    dly_c  = filt_delay(mode, f);
    if (int'(dly_c) + 1 > DELAY_DEPTH) len_c = LW'(DELAY_DEPTH);
    else                               len_c = LW'({1'b0, dly_c} + 14'd1);
    p_ext  = LW'(ring_pos[row_c]);
    p_c    = (p_ext >= len_c) ? '0 : p_ext;
    pm1_c  = (p_c == '0) ? len_c - LW'(1) : p_c - LW'(1);
    pd_c   = (p_c + LW'(1) >= len_c) ? '0 : p_c + LW'(1);
  end

  // memory port control
  always_comb begin
    rd_en   = (state == ST_RD1) || (state == ST_RD2);
    rd_addr = (state == ST_RD1) ? base + AW'(pm1) : base + AW'(pd);
    wr_en   = (state == ST_CLEAR) || (state == ST_WR);
    wr_addr = (state == ST_CLEAR) ? clr_cnt : base + AW'(p);
    wr_x    = (state == ST_CLEAR) ? '0 : xin;
    wr_y    = (state == ST_CLEAR) ? '0 : y;
  end

  // history memories, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      xmem[wr_addr] <= wr_x;
      ymem[wr_addr] <= wr_y;
    end
    if (rd_en) begin
      xq <= xmem[rd_addr];
      yq <= ymem[rd_addr];
    end
  end

  // accumulator terms by filter kind
  logic signed [ACCW-1:0] acc_next, rnd_sum;
  logic signed [SB-1:0]   y_next;
  logic signed [SB+3:0]   sum_next;
  always_comb begin
    case (kind)
      K_LOWPASS: acc_next = (ACCW'(xin) <<< 29) - (ACCW'(m1) <<< 13)
                            + (ACCW'(m2) <<< 16) + ACCW'(m4);
      K_FFCOMB:  acc_next = ACCW'(m1) + (ACCW'(xd) <<< 16);
      K_APJC:    acc_next = ACCW'(m1) + (ACCW'(xd) <<< 16) - ACCW'(m2);
      default:   acc_next = -(ACCW'(xin) <<< 15) + (ACCW'(xd) <<< 16) + (ACCW'(yd) <<< 15);
    endcase
    case (kind)
      K_LOWPASS: rnd_sum = (acc + (ACCW'(1) <<< 31)) >>> 32;
      K_FFCOMB:  rnd_sum = (acc + (ACCW'(1) <<< 17)) >>> 18;
      default:   rnd_sum = (acc + (ACCW'(1) <<< 15)) >>> 16;
    endcase
    y_next   = sat_acc(rnd_sum);
    sum_next = sum + (SB+4)'(y);
  end

  // filter sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < ROWS; i++) ring_pos[i] <= '0;
    end else begin
      // the done state reloads the result register itself
      if (out_valid && result.ready && (state != ST_DONE)) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(MEM_DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (sample_req.valid) begin
            ch   <= sample_req.channel;
            s_in <= sample_req.sample_in;
            f    <= '0;
            sum  <= '0;
            if (int'(sample_req.channel) >= CHANNELS) begin
              res   <= '0;
              state <= ST_DONE;
            end else begin
              state <= ST_ADDR;
            end
          end
        end
        ST_ADDR: begin
          row   <= row_c;
          base  <= AW'(int'(row_c) * DELAY_DEPTH);
          p     <= PW'(p_c);
          pm1   <= PW'(pm1_c);
          pd    <= PW'(pd_c);
          kind  <= filt_kind(mode, f);
          xin   <= (f < n_comb) ? s_in : v;
          state <= ST_RD1;
        end
        ST_RD1: state <= ST_RD2;
        ST_RD2: begin
          x1    <= xq;
          y1    <= yq;
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          xd    <= xq;
          yd    <= yq;
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          case (kind)
            K_LOWPASS: begin
              m1 <= x1 * $signed({1'b0, damping});
              m2 <= y1 * $signed({1'b0, damping});
            end
            K_FFCOMB: begin
              m1 <= xin * $signed({1'b0, jc_coef(f[1:0])});
              m2 <= '0;
            end
            default: begin
              m1 <= xin * $signed({1'b0, allpass_gain});
              m2 <= yd * $signed({1'b0, allpass_gain});
            end
          endcase
          m3    <= room_size * (17'h10000 - {1'b0, damping});
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          m4    <= yd * $signed({1'b0, m3});
          state <= ST_ACC;
        end
        ST_ACC: begin
          acc   <= acc_next;
          state <= ST_RND;
        end
        ST_RND: begin
          y     <= y_next;
          state <= ST_WR;
        end
        ST_WR: begin
          ring_pos[row] <= pd;
          if (f < n_comb) begin
            sum <= sum_next;
            if (f == n_comb - 4'd1) v <= sat_acc(ACCW'(sum_next));
          end else begin
            v <= y;
          end
          if (f == n_filt - 4'd1) begin
            res   <= y;
            state <= ST_DONE;
          end else begin
            f     <= f + 4'd1;
            state <= ST_ADDR;
          end
        end
        ST_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_ch     <= ch;
            out_sample <= res;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // no request is taken while the history memories are being cleared
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !sample_req.ready)
    else $error("request accepted during clearing pass");

  // reads stay inside the history memories
  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (int'(rd_addr) < MEM_DEPTH))
    else $error("history read out of range");

  // a write-back leaves the ring position inside the store
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR) |=> (int'(ring_pos[row]) < DELAY_DEPTH))
    else $error("ring position beyond delay depth");

  // the filter index never passes the structure's filter count
  a_filter_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADDR) |-> (f < n_filt))
    else $error("filter index out of range");
`endif

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// self-checking bench for the comb/allpass reverberator with a bit-exact predictor
module tb;
  import car_pkg::*;

  localparam int  N_CH     = 2;
  localparam int  N_SLOT   = 12;
  localparam int  DEPTH    = 8192;
  localparam int  LIMIT    = 3000000;
  localparam int  TAIL     = 150;
  localparam int  LONG_OFF = 2500;

  typedef struct packed {
    logic               ch;
    logic signed [15:0] smp;
  } reverb_out_t;

  typedef struct {
    logic               ch;
    logic signed [15:0] smp;
    bit                 fixed;
    logic signed [15:0] fixed_val;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  car_in_if  #(16) sample_req ();
  car_out_if #(16) result ();
  car_cfg_if       cfg ();

  comb_allpass_reverb i_dut (
    .clk        (clk),
    .rst        (rst),
    .sample_req (sample_req),
    .result     (result),
    .cfg        (cfg)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: delay rings, write positions and register copies
  shortint     x_hist [N_CH][N_SLOT][DEPTH];
  shortint     y_hist [N_CH][N_SLOT][DEPTH];
  int unsigned ring_pos [N_CH][N_SLOT];
  logic        cur_mode;
  logic [15:0] cur_room, cur_damp, cur_gain;

  reverb_out_t exp_q [$];
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  logic        req_fire = 1'b0;
  logic        cfg_fire = 1'b0;
  bit          req_fixed = 1'b0;
  logic signed [15:0] req_fixed_val = '0;
  int          hold_reqs = 0;

  int fv_delay [12] = '{1557, 1617, 1491, 1422, 1277, 1356, 1188, 1116, 225, 556, 441, 341};
  int jc_delay [7]  = '{4799, 4999, 5399, 5899, 1051, 337, 113};
  longint jc_gain [4] = '{48628, 48038, 46858, 45679};

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // round to nearest, halves toward +inf
  function automatic longint round_down(longint acc, int k);
    return (acc + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  // one filter stage on its ring
  function automatic logic signed [15:0] filter_stage(int ch, int slot, int dly,
                                                     logic [1:0] kind, longint coef,
                                                     longint xin);
    int     len, p, pm1, pd;
    longint x1, y1, xd, yd, acc, d, rs, g;
    logic signed [15:0] y;
    len = dly + 1;
    if (len > DEPTH) len = DEPTH;
    p = ring_pos[ch][slot];
    if (p >= len) p = 0;
    pm1 = (p == 0) ? len - 1 : p - 1;
    pd  = (p + 1 >= len) ? 0 : p + 1;
    x_hist[ch][slot][p] = shortint'(xin);
    x1 = x_hist[ch][slot][pm1];
    y1 = y_hist[ch][slot][pm1];
    xd = x_hist[ch][slot][pd];
    yd = y_hist[ch][slot][pd];
    d  = longint'(cur_damp);
    rs = longint'(cur_room);
    g  = longint'(cur_gain);
    case (kind)
      K_LOWPASS: begin
        acc = xin * (64'sd1 <<< 29) - x1 * d * 8192 + y1 * d * 65536 + yd * rs * (65536 - d);
        y = sat16(round_down(acc, 32));
      end
      K_FFCOMB: begin
        acc = coef * xin + xd * 65536;
        y = sat16(round_down(acc, 18));
      end
      K_APJC: begin
        acc = g * xin + xd * 65536 - g * yd;
        y = sat16(round_down(acc, 16));
      end
      default: begin
        acc = -32768 * xin + xd * 65536 + 32768 * yd;
        y = sat16(round_down(acc, 16));
      end
    endcase
    y_hist[ch][slot][p] = y;
    ring_pos[ch][slot] = pd;
    return y;
  endfunction

  // reverberated sample for one request
  function automatic logic signed [15:0] reverb_sample(int ch, logic signed [15:0] s);
    longint sum;
    logic signed [15:0] v;
    sum = 0;
    if (cur_mode == MODE_FREEVERB) begin
      for (int i = 0; i < 8; i++) sum += filter_stage(ch, i, fv_delay[i], K_LOWPASS, 0, s);
      v = sat16(sum);
      for (int i = 0; i < 4; i++) v = filter_stage(ch, 8 + i, fv_delay[8 + i], K_DIFFUSE, 0, v);
    end else begin
      for (int i = 0; i < 4; i++)
        sum += filter_stage(ch, i, jc_delay[i], K_FFCOMB, jc_gain[i], s);
      v = sat16(sum);
      for (int i = 0; i < 3; i++) v = filter_stage(ch, 4 + i, jc_delay[4 + i], K_APJC, 0, v);
    end
    return v;
  endfunction

  task automatic report(string what, reverb_out_t got, reverb_out_t want);
    $display("[%0t] %s: got ch %0d sample %0d, want ch %0d sample %0d",
             $time, what, got.ch, got.smp, want.ch, want.smp);
    fail_cnt++;
  endtask

  // request and config monitor, predictor update on acceptance
  always @(posedge clk) begin
    reverb_out_t e;
    req_fire <= !rst && sample_req.valid && sample_req.ready;
    cfg_fire <= !rst && cfg.valid && cfg.ready;
    if (!rst && cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MODE:         cur_mode = cfg.data[0];
        REG_ROOM_SIZE:    cur_room = cfg.data;
        REG_DAMPING:      cur_damp = cfg.data;
        REG_ALLPASS_GAIN: cur_gain = cfg.data;
        default: ;
      endcase
    end
    if (!rst && sample_req.valid && sample_req.ready) begin
      e.ch  = sample_req.channel;
      e.smp = reverb_sample(int'(sample_req.channel), sample_req.sample_in);
      if (req_fixed) e.smp = req_fixed_val;
      exp_q.push_back(e);
    end
  end

  // result checker
  always @(posedge clk) begin
    reverb_out_t got, want;
    if (!rst && result.valid && result.ready) begin
      got.ch  = result.out_channel;
      got.smp = result.sample_out;
      if (exp_q.size() == 0) begin
        report("unexpected result", got, got);
      end else begin
        want = exp_q.pop_front();
        if (got.ch !== want.ch) report("channel mismatch", got, want);
        if (got.smp !== want.smp) report("sample mismatch", got, want);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: randomly free or choppy stretches, plus one long hold-off
  initial begin
    int hold_left, stretch, hold_seen;
    bit choppy;
    hold_left = 0;
    stretch = 0;
    hold_seen = 0;
    choppy = 1'b0;
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = LONG_OFF;
      end
      if (stretch == 0) begin
        choppy = 1'($urandom_range(0, 1));
        stretch = $urandom_range(50, 400);
      end
      stretch--;
      if (hold_left > 0) begin
        hold_left--;
        result.ready = 1'b0;
      end else begin
        result.ready = choppy ? ($urandom_range(0, 99) >= 40) : 1'b1;
      end
    end
  end

  // one sample request, held until taken
  task automatic send_sample(logic ch, logic signed [15:0] s, bit fixed,
                             logic signed [15:0] fixed_val);
    sample_req.valid   = 1'b1;
    sample_req.channel = ch;
    sample_req.sample_in = s;
    req_fixed = fixed;
    req_fixed_val = fixed_val;
    do @(negedge clk); while (!req_fire);
  endtask

  task automatic idle_sender(int n);
    sample_req.valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = val;
    do @(negedge clk); while (!cfg_fire);
    cfg.valid = 1'b0;
  endtask

  task automatic wait_drained();
    sample_req.valid = 1'b0;
    while (exp_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_regs(logic m, logic [15:0] rs, logic [15:0] dp, logic [15:0] g);
    wait_drained();
    write_reg(REG_MODE, {15'd0, m});
    write_reg(REG_ROOM_SIZE, rs);
    write_reg(REG_DAMPING, dp);
    write_reg(REG_ALLPASS_GAIN, g);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 9))
      6, 7:    return $signed(16'($urandom_range(0, 511))) - 16'sd256;
      8:       return $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
      9:       return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  // random bursts with random gaps, some stretches back to back
  task automatic random_phase(int n, bit long_hold);
    int sent, burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < n; i++) begin
        if (long_hold && sent == n / 2) hold_reqs++;
        send_sample(1'($urandom_range(0, 1)), rand_sample(), 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 20));
    end
  endtask

  // directed rows: silence on fresh rings, then extremes on both channels
  stim_row_t dir_rows [16] = '{
    '{1'b0, 16'sd0,      1'b1, 16'sd0},
    '{1'b1, 16'sd0,      1'b1, 16'sd0},
    '{1'b0, 16'sd32767,  1'b0, 16'sd0},
    '{1'b1, -16'sd32768, 1'b0, 16'sd0},
    '{1'b0, -16'sd32768, 1'b0, 16'sd0},
    '{1'b1, 16'sd32767,  1'b0, 16'sd0},
    '{1'b0, -16'sd1,     1'b0, 16'sd0},
    '{1'b1, 16'sd1,      1'b0, 16'sd0},
    '{1'b0, 16'sh5555,   1'b0, 16'sd0},
    '{1'b1, -16'sh5556,  1'b0, 16'sd0},
    '{1'b0, 16'sd0,      1'b0, 16'sd0},
    '{1'b1, 16'sd0,      1'b0, 16'sd0},
    '{1'b0, 16'sd32767,  1'b0, 16'sd0},
    '{1'b0, 16'sd32767,  1'b0, 16'sd0},
    '{1'b1, -16'sd32768, 1'b0, 16'sd0},
    '{1'b1, -16'sd32768, 1'b0, 16'sd0}
  };

  // main sequence
  initial begin
    cur_mode = MODE_FREEVERB;
    cur_room = ROOM_SIZE_RST;
    cur_damp = DAMPING_RST;
    cur_gain = ALLPASS_GAIN_RST;
    sample_req.valid = 1'b0;
    sample_req.channel = 1'b0;
    sample_req.sample_in = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed part at reset settings, also a short JCRev pass
    foreach (dir_rows[i])
      send_sample(dir_rows[i].ch, dir_rows[i].smp, dir_rows[i].fixed, dir_rows[i].fixed_val);
    set_regs(MODE_JCREV, ROOM_SIZE_RST, DAMPING_RST, ALLPASS_GAIN_RST);
    for (int i = 0; i < 6; i++) send_sample(i[0], dir_rows[2 + i].smp, 1'b0, '0);

    // random phases over register extremes and random settings; mode flips with filled rings
    set_regs(MODE_FREEVERB, 16'hFFFF, 16'h0000, ALLPASS_GAIN_RST);
    random_phase(400, 1'b0);
    set_regs(MODE_JCREV, 16'hFFFF, 16'h0000, 16'hFFFF);
    random_phase(300, 1'b0);
    set_regs(MODE_FREEVERB, 16'h0000, 16'hFFFF, 16'h0000);
    random_phase(300, 1'b0);
    set_regs(MODE_JCREV, 16'h0000, 16'hFFFF, 16'h0000);
    random_phase(300, 1'b0);
    set_regs(MODE_FREEVERB, 16'($urandom), 16'($urandom), 16'($urandom));
    random_phase(300, 1'b1);
    set_regs(MODE_JCREV, 16'($urandom), 16'($urandom), 16'($urandom));
    random_phase(200, 1'b0);

    // drain and settle
    wait_drained();
    repeat (TAIL) @(negedge clk);
    if (fail_cnt == 0 && exp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
